FILE: src/mgmr_pkg.sv
`timescale 1ns / 1ps
package mgmr_pkg;

  localparam int GRID_DIM_DEF = 32;
  localparam int COORD_W      = 5;
  localparam int VAL_W        = 32;
  localparam int EPS_W        = 31;
  localparam int CMD_W        = 3;
  localparam int STAT_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int FRAC_BITS    = 16;
  localparam int QUO_W        = FRAC_BITS + 1;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESCALE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MIN     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MAX     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SKIPPED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NONE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPS      = 2'd2;

  localparam logic signed [VAL_W-1:0] MIN_SENT_RST = 32'sd0;
  localparam logic signed [VAL_W-1:0] MAX_SENT_RST = 32'sd65536;
  localparam logic [EPS_W-1:0]        EPS_RST      = 31'd1;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [VAL_W-1:0]   cell_value;
    logic                      cell_admissible;
    logic [COORD_W-1:0]        row_lo;
    logic [COORD_W-1:0]        row_hi;
    logic [COORD_W-1:0]        col_lo;
    logic [COORD_W-1:0]        col_hi;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [STAT_W-1:0]       status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDONE,
    ST_RD,
    ST_EV,
    ST_DIV,
    ST_END,
    ST_FIN
  } state_t;

endpackage

FILE: src/masked_grid_minmax_rescale_top.sv
`timescale 1ns / 1ps
// After reset the block sweeps every cell of the cell store to zero, one cell
// per cycle, and takes no item meanwhile. It works on one item at a time
// through a single-port store: window min and max read each window cell once,
// and rescale, when the first pass finds an admissible cell and a positive span
// of at least eps, makes a second pass over the window with one division by the
// bit-serial divider (17 quotient bits) for each admissible cell.
module masked_grid_minmax_rescale_top #(
  parameter int GRID_DIM = mgmr_pkg::GRID_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mgmr_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mgmr_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [mgmr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mgmr_pkg::VAL_W-1:0]        cfg_data
);
  import mgmr_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = VAL_W + 1;

  state_t state, state_next;

  logic signed [VAL_W-1:0] min_sent;
  logic signed [VAL_W-1:0] max_sent;
  logic [EPS_W-1:0]        eps;

  logic [CMD_W-1:0]        cmd;
  logic [COORD_W-1:0]      rl, rh, cl, ch, rc, cc;
  logic signed [VAL_W-1:0] mn, mx, rd_val;
  logic                    found, skip, pass;
  logic [AW-1:0]           clr_cnt;

  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  logic [WW-1:0]           ram_wdata, ram_rdata;
  logic                    div_start, div_done;
  logic [QUO_W-1:0]        div_q;
  logic [VAL_W-1:0]        div_dividend, span_u;

  logic                    accept, in_grid, empty, last, fin_go, skip_now;
  logic [COORD_W-1:0]      rl_c, rh_c, cl_c, ch_c;
  logic signed [VAL_W:0]   span;
  logic signed [VAL_W-1:0] cur_v;
  logic                    cur_mark;
  logic [AW-1:0]           cell_idx, in_idx;

  function automatic logic [COORD_W-1:0] clip(input logic [COORD_W-1:0] v);
    clip = (int'(v) >= GRID_DIM) ? COORD_W'(GRID_DIM - 1) : v;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_grid  = (int'(in_data.row) < GRID_DIM) && (int'(in_data.col) < GRID_DIM);
  assign rl_c     = clip(in_data.row_lo);
  assign rh_c     = clip(in_data.row_hi);
  assign cl_c     = clip(in_data.col_lo);
  assign ch_c     = clip(in_data.col_hi);
  assign empty    = (int'(in_data.row_lo) >= GRID_DIM) || (int'(in_data.col_lo) >= GRID_DIM)
                    || (rl_c > rh_c) || (cl_c > ch_c);
  assign in_idx   = AW'(AW'(in_data.row) * AW'(GRID_DIM) + AW'(in_data.col));
  assign cell_idx = AW'(AW'(rc) * AW'(GRID_DIM) + AW'(cc));
  assign last     = (rc == rh) && (cc == ch);
  assign cur_v    = ram_rdata[VAL_W-1:0];
  assign cur_mark = ram_rdata[VAL_W];
  assign span     = {mx[VAL_W-1], mx} - {mn[VAL_W-1], mn};
  assign span_u   = span[VAL_W-1:0];
  assign skip_now = (span <= 0) || (span < $signed({2'b00, eps}));
  assign div_dividend = VAL_W'({cur_v[VAL_W-1], cur_v} - {mn[VAL_W-1], mn});
  assign fin_go   = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_READ && in_grid) begin
            state_next = ST_RDONE;
          end else if ((in_data.cmd == CMD_RESCALE || in_data.cmd == CMD_MIN ||
                        in_data.cmd == CMD_MAX) && !empty) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_RDONE: state_next = ST_FIN;
      ST_RD:    state_next = ST_EV;
      ST_EV: begin
        if (pass && cur_mark) state_next = ST_DIV;
        else if (last)        state_next = ST_END;
        else                  state_next = ST_RD;
      end
      ST_DIV: begin
        if (div_done) state_next = last ? ST_END : ST_RD;
      end
      ST_END: begin
        if (!pass && cmd == CMD_RESCALE && found && !skip_now) state_next = ST_RD;
        else                                                  state_next = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = cell_idx;
    ram_wdata = {1'b1, VAL_W'(div_q)};
    div_start = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_addr  = in_idx;
        ram_wdata = {in_data.cell_admissible, in_data.cell_value};
        ram_we    = accept && in_grid && (in_data.cmd == CMD_WRITE);
      end
      ST_EV:  div_start = pass && cur_mark;
      ST_DIV: ram_we    = div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      min_sent  <= MIN_SENT_RST;
      max_sent  <= MAX_SENT_RST;
      eps       <= EPS_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == ST_FIN && fin_go) out_valid <= 1'b1;
      else if (out_ready)            out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_SENT: min_sent <= cfg_data;
          REG_MAX_SENT: max_sent <= cfg_data;
          REG_EPS:      eps      <= cfg_data[EPS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd    <= in_data.cmd;
        rl     <= rl_c;
        rh     <= rh_c;
        cl     <= cl_c;
        ch     <= ch_c;
        rc     <= rl_c;
        cc     <= cl_c;
        mn     <= max_sent;
        mx     <= min_sent;
        found  <= 1'b0;
        skip   <= 1'b0;
        pass   <= 1'b0;
        rd_val <= '0;
      end
      ST_RDONE: rd_val <= cur_v;
      ST_EV: begin
        if (!pass && cur_mark) begin
          found <= 1'b1;
          if (cur_v < mn) mn <= cur_v;
          if (cur_v > mx) mx <= cur_v;
        end
        if (!(pass && cur_mark) && !last) begin
          if (cc == ch) begin
            cc <= cl;
            rc <= rc + 1'b1;
          end else begin
            cc <= cc + 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done && !last) begin
          if (cc == ch) begin
            cc <= cl;
            rc <= rc + 1'b1;
          end else begin
            cc <= cc + 1'b1;
          end
        end
      end
      ST_END: begin
        if (!pass && cmd == CMD_RESCALE && found) begin
          if (skip_now) begin
            skip <= 1'b1;
          end else begin
            pass <= 1'b1;
            rc   <= rl;
            cc   <= cl;
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          case (cmd)
            CMD_READ: out_data.result_value <= rd_val;
            CMD_MIN:  out_data.result_value <= mn;
            CMD_MAX:  out_data.result_value <= mx;
            default:  out_data.result_value <= '0;
          endcase
          if ((cmd == CMD_RESCALE || cmd == CMD_MIN || cmd == CMD_MAX) && !found) begin
            out_data.status <= STAT_NONE;
          end else if (skip) begin
            out_data.status <= STAT_SKIPPED;
          end else begin
            out_data.status <= STAT_DONE;
          end
        end
      end
      default: ;
    endcase
  end

  mgmr_ram #(
    .WIDTH(WW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  mgmr_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (span_u),
    .done    (div_done),
    .quotient(div_q)
  );

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("item taken during store clearing");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("illegal status code");

  a_rescale_write_only_pass2: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_IDLE && state != ST_CLEAR) |-> (pass && cmd == CMD_RESCALE))
    else $error("store written outside rescale pass");
`endif

endmodule

FILE: src/mgmr_ram.sv
`timescale 1ns / 1ps
module mgmr_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: src/mgmr_div.sv
`timescale 1ns / 1ps
module mgmr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mgmr_pkg::VAL_W-1:0]    dividend,
  input  logic [mgmr_pkg::VAL_W-1:0]    divisor,
  output logic                          done,
  output logic [mgmr_pkg::QUO_W-1:0]    quotient
);
  import mgmr_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [VAL_W:0]   rem;
  logic [VAL_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [VAL_W+1:0] diff;
  logic             qbit;
  logic [VAL_W:0]   rem_sel;

  assign diff    = {1'b0, rem} - {2'b00, dsr};
  assign qbit    = !diff[VAL_W+1];
  assign rem_sel = qbit ? diff[VAL_W:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= {rem_sel[VAL_W-1:0], 1'b0};
      quotient <= {quotient[QUO_W-2:0], qbit};
    end
  end

endmodule
